/* hw/rtl/smbrx_pkg.sv */
// smbrx_pkg: shared types and constants for the SMBus receive-byte master.
// No dependencies.
`timescale 1ns / 1ps

package smbrx_pkg;

    localparam int TICKS_PER_FRAME = 80;
    localparam int TICK_W          = 7;
    localparam int SLOT_W          = 5;
    localparam int ADDR_W          = 7;
    localparam int BYTE_W          = 8;

    localparam logic [TICK_W-1:0] LAST_TICK = TICK_W'(TICKS_PER_FRAME - 1);

    // slot map of one frame (4 ticks per slot)
    localparam logic [SLOT_W-1:0] SLOT_START      = 5'd0;
    localparam logic [SLOT_W-1:0] SLOT_ADDR_FIRST = 5'd1;
    localparam logic [SLOT_W-1:0] SLOT_ADDR_LAST  = 5'd7;
    localparam logic [SLOT_W-1:0] SLOT_DATA_FIRST = 5'd10;
    localparam logic [SLOT_W-1:0] SLOT_DATA_LAST  = 5'd17;
    localparam logic [SLOT_W-1:0] SLOT_STOP       = 5'd19;

    // request codes
    localparam logic REQ_START = 1'b0;
    localparam logic REQ_TICK  = 1'b1;

    typedef struct packed {
        logic req_type;
        logic sda_in_first;
        logic sda_in_second;
    } t_in_item;

    typedef struct packed {
        logic                     scl_level;
        logic                     sda_level;
        logic                     busy_res;
        logic                     frame_done;
        logic signed [BYTE_W-1:0] reading_first;
        logic signed [BYTE_W-1:0] reading_second;
    } t_out_item;

endpackage

/* hw/rtl/smbrx_frame.sv */
// smbrx_frame: frame tick counter, SCL/SDA generation and data capture.
// Depends on smbrx_pkg.
`timescale 1ns / 1ps

module smbrx_frame (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_en,
    input  smbrx_pkg::t_in_item              i_item,
    input  logic [smbrx_pkg::ADDR_W-1:0]     i_dev_addr,
    output smbrx_pkg::t_out_item             o_result
);

    logic [smbrx_pkg::TICK_W-1:0] r_tick, n_tick;
    logic                         r_active, n_active;
    logic [smbrx_pkg::BYTE_W-1:0] r_shift_first, n_shift_first;
    logic [smbrx_pkg::BYTE_W-1:0] r_shift_second, n_shift_second;

    logic [smbrx_pkg::SLOT_W-1:0] slot;
    logic                         scl;
    logic                         sda;
    logic                         sda_slot;
    logic                         data_slot;
    logic                         done;
    logic [2:0]                   addr_bit;
    logic [2:0]                   data_bit;

    assign slot      = r_tick[smbrx_pkg::TICK_W-1:2];
    assign addr_bit  = 3'(smbrx_pkg::SLOT_ADDR_LAST - slot);
    assign data_bit  = 3'(smbrx_pkg::SLOT_DATA_LAST - slot);
    assign data_slot = (slot >= smbrx_pkg::SLOT_DATA_FIRST) &&
                       (slot <= smbrx_pkg::SLOT_DATA_LAST);
    assign done      = (r_tick >= smbrx_pkg::LAST_TICK);

    always_comb begin
        if (slot == smbrx_pkg::SLOT_START || slot == smbrx_pkg::SLOT_STOP) begin
            sda_slot = 1'b0;
        end else if (slot >= smbrx_pkg::SLOT_ADDR_FIRST &&
                     slot <= smbrx_pkg::SLOT_ADDR_LAST) begin
            sda_slot = i_dev_addr[addr_bit];
        end else begin
            sda_slot = 1'b1;
        end
    end

    // low, high, high, low within a slot; held high at frame edges
    assign scl = (r_tick[1] ^ r_tick[0])
               | (r_tick < 7'd3)
               | (r_tick >= smbrx_pkg::LAST_TICK - 7'd2);
    assign sda = sda_slot
               | (r_tick < 7'd2)
               | (r_tick >= smbrx_pkg::LAST_TICK - 7'd1);

    always_comb begin
        n_tick         = r_tick;
        n_active       = r_active;
        n_shift_first  = r_shift_first;
        n_shift_second = r_shift_second;
        o_result       = '0;
        o_result.scl_level = 1'b1;
        o_result.sda_level = 1'b1;
        if (i_item.req_type == smbrx_pkg::REQ_START) begin
            n_tick            = '0;
            n_active          = 1'b1;
            n_shift_first     = '0;
            n_shift_second    = '0;
            o_result.busy_res = 1'b1;
        end else if (r_active) begin
            if (scl && data_slot) begin
                n_shift_first[data_bit]  = i_item.sda_in_first;
                n_shift_second[data_bit] = i_item.sda_in_second;
            end
            o_result.scl_level = scl;
            o_result.sda_level = sda;
            o_result.busy_res  = 1'b1;
            if (done) begin
                n_tick                  = '0;
                n_active                = 1'b0;
                o_result.frame_done     = 1'b1;
                o_result.reading_first  = n_shift_first;
                o_result.reading_second = n_shift_second;
            end else begin
                n_tick = r_tick + 7'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick         <= '0;
            r_active       <= 1'b0;
            r_shift_first  <= '0;
            r_shift_second <= '0;
        end else if (i_en) begin
            r_tick         <= n_tick;
            r_active       <= n_active;
            r_shift_first  <= n_shift_first;
            r_shift_second <= n_shift_second;
        end
    end

    a_tick_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tick <= smbrx_pkg::LAST_TICK)
        else $error("tick count beyond frame end");

    a_idle_tick_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_active |-> r_tick == '0)
        else $error("tick count nonzero while idle");

endmodule

/* hw/rtl/smbus_receive_byte_master_unit.sv */
// smbus_receive_byte_master_unit: top level of the SMBus receive-byte master.
// Depends on smbrx_pkg and smbrx_frame.
`timescale 1ns / 1ps

//  channel | direction | payload      | handshake
//  --------+-----------+--------------+------------------------------
//  in      | into unit | t_in_item    | i_in_valid / o_in_stall
//  out     | from unit | t_out_item   | o_out_valid / i_out_stall
//  cfg     | into unit | device addr  | i_cfg_we / i_cfg_wdata
//
//  The frame logic works from the item and the frame state in one pass,
//  and the result lands in the output register.
//  A new item is taken every cycle while the output register is empty or is
//  being drained in the same cycle; i_out_stall alone holds the input off.
//  Reset (synchronous, active low) idles the frame, clears the captured bytes
//  and the device address, and empties the output register.

module smbus_receive_byte_master_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,

    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  smbrx_pkg::t_in_item          i_in,

    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output smbrx_pkg::t_out_item         o_out,

    input  logic                         i_cfg_we,
    input  logic [smbrx_pkg::ADDR_W-1:0] i_cfg_wdata
);

    logic [smbrx_pkg::ADDR_W-1:0] r_dev_addr;
    logic                         r_out_valid;
    smbrx_pkg::t_out_item         r_out;

    smbrx_pkg::t_out_item         frame_result;
    logic                         in_accept;
    logic                         out_accept;

    // output register drains and refills in the same cycle
    assign o_in_stall  = r_out_valid & i_out_stall;
    assign in_accept   = i_in_valid & ~o_in_stall;
    assign out_accept  = r_out_valid & ~i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    smbrx_frame u_frame (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (in_accept),
        .i_item     (i_in),
        .i_dev_addr (r_dev_addr),
        .o_result   (frame_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_dev_addr <= i_cfg_wdata;
            end
            if (in_accept) begin
                r_out_valid <= 1'b1;
            end else if (out_accept) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out <= frame_result;
        end
    end

    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> o_out_valid)
        else $error("accepted item produced no result");

    a_done_implies_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.frame_done |-> o_out.busy_res && o_out.scl_level)
        else $error("frame done without busy or with SCL low");

endmodule
